FILE: rtl/rbfsr_pkg.sv
// ----------------------------------------------------------------------------
// rbfsr_pkg
// Shared constants, command/status types and helpers for the ROM bank
// free-space ranker.
// ----------------------------------------------------------------------------
package rbfsr_pkg;

    localparam int NUM_BANKS_DEF = 128;

    localparam int END_W   = 16;
    localparam int TOTAL_W = 23;
    localparam int PCT_W   = 16;

    localparam logic [END_W-1:0] BANK0_BASE = 16'h4000;
    localparam logic [END_W-1:0] BANK_BASE  = 16'h8000;
    localparam logic [END_W-1:0] END_RST    = 16'h4000;

    // percentage = ((total * 20000) >> 14) / banks, then halved with rounding
    localparam int PCT_SCALE = 20000;
    localparam int PCT_SHIFT = 14;
    localparam int PROD_W    = 38;
    localparam int QUO_W     = PROD_W - PCT_SHIFT;
    localparam logic [PCT_W-1:0] PCT_RST = 16'd10000;

    typedef struct packed {
        logic load;
        logic rec_rd;
        logic rec_upd;
        logic scan_start;
        logic scan_run;
        logic shift_start;
        logic shift_run;
        logic place;
        logic div_start;
        logic q_ord;
        logic q_end;
        logic res_load;
    } rbfsr_cmd_t;

    typedef struct packed {
        logic mode;
        logic bank_bad;
        logic upd;
        logic scan_done;
        logic shift_done;
        logic div_busy;
        logic out_free;
    } rbfsr_stat_t;

    function automatic logic [END_W-1:0] bank_free(input logic is_bank0,
                                                   input logic [END_W-1:0] end_addr);
        logic [END_W-1:0] base;
        base = is_bank0 ? BANK0_BASE : BANK_BASE;
        return base - end_addr;
    endfunction

endpackage

FILE: rtl/rbfsr_div.sv
// ----------------------------------------------------------------------------
// rbfsr_div
// Free-percentage unit: one multiply by the scale, then division by the bank
// count through a reciprocal multiply; a start is taken only while idle.
// ----------------------------------------------------------------------------
module rbfsr_div #(
    parameter int NUM_BANKS = rbfsr_pkg::NUM_BANKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [rbfsr_pkg::TOTAL_W-1:0]   total,
    output logic                            busy,
    output logic [rbfsr_pkg::PCT_W-1:0]     pct
);
    import rbfsr_pkg::*;

    // floor(q / NUM_BANKS) == (q * RCP_M) >> RCP_SH for every q below 2^QUO_W,
    // with RCP_M = ceil(2^RCP_SH / NUM_BANKS)
    localparam int RCP_L   = $clog2(NUM_BANKS);
    localparam int RCP_SH  = QUO_W + RCP_L;
    localparam int RCP_W   = QUO_W + 1;
    localparam int RPROD_W = QUO_W + RCP_W;
    localparam logic [63:0] RCP_ML =
        ((64'd1 << RCP_SH) + 64'(NUM_BANKS) - 64'd1) / 64'(NUM_BANKS);
    localparam logic [RCP_W-1:0] RCP_M = RCP_ML[RCP_W-1:0];

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_MUL  = 3'b010,
        D_RCP  = 3'b100
    } div_state_t;

    div_state_t         state_reg, state_next;
    logic [TOTAL_W-1:0] tot_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [PCT_W-1:0]   pct_reg;
    logic [PROD_W-1:0]  prod;
    logic [RPROD_W-1:0] rprod;
    logic [PCT_W-1:0]   rquo;
    logic [PCT_W:0]     rnd;

    assign prod  = PROD_W'(tot_reg) * PROD_W'(PCT_SCALE);
    assign rprod = RPROD_W'(quo_reg) * RPROD_W'(RCP_M);
    assign rquo  = PCT_W'(rprod >> RCP_SH);
    assign rnd   = {1'b0, rquo} + (PCT_W+1)'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE:  if (start) state_next = D_MUL;
            D_MUL:   state_next = D_RCP;
            D_RCP:   state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            pct_reg   <= PCT_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == D_RCP)
                pct_reg <= rnd[PCT_W:1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && start)
            tot_reg <= total;
        if (state_reg == D_MUL)
            quo_reg <= prod[PROD_W-1:PCT_SHIFT];
    end

    assign busy = (state_reg != D_IDLE);
    assign pct  = pct_reg;

endmodule

FILE: rtl/rbfsr_dp.sv
// ----------------------------------------------------------------------------
// rbfsr_dp
// Datapath: bank end table, rank order memory, scan and shift pipelines,
// running free total, percentage unit and result register.
// ----------------------------------------------------------------------------
module rbfsr_dp #(
    parameter int NUM_BANKS = rbfsr_pkg::NUM_BANKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            mode,
    input  logic [7:0]                      bank,
    input  logic [15:0]                     address,
    input  logic [15:0]                     length,
    input  logic [6:0]                      rank,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            error,
    output logic [6:0]                      ranked_bank,
    output logic [15:0]                     ranked_free,
    output logic [15:0]                     ranked_end,
    output logic [rbfsr_pkg::TOTAL_W-1:0]   total_free,
    output logic [rbfsr_pkg::PCT_W-1:0]     percent_hundredths,
    input  rbfsr_pkg::rbfsr_cmd_t           cmd,
    output rbfsr_pkg::rbfsr_stat_t          stat
);
    import rbfsr_pkg::*;

    localparam int BW = $clog2(NUM_BANKS);
    localparam int CW = $clog2(NUM_BANKS + 1);
    localparam logic [TOTAL_W-1:0] TOTAL_RST =
        TOTAL_W'((NUM_BANKS * 16384) % (1 << TOTAL_W));

    // item capture
    logic               mode_reg;
    logic [7:0]         bank_reg;
    logic [15:0]        addr_reg;
    logic [15:0]        len_reg;
    logic [6:0]         rank_reg;

    // memories with per-entry valid bits
    logic [END_W-1:0]     end_mem [NUM_BANKS];
    logic [BW-1:0]        ord_mem [NUM_BANKS];
    logic [NUM_BANKS-1:0] end_vld_reg;
    logic [NUM_BANKS-1:0] ord_vld_reg;

    logic [END_W-1:0]   end_rd_reg;
    logic               end_rv_reg;
    logic [BW-1:0]      end_ra_reg;
    logic [BW-1:0]      ord_rd_reg;
    logic               ord_rv_reg;
    logic [BW-1:0]      ord_ra_reg;

    logic [END_W-1:0]   end_val;
    logic [BW-1:0]      ord_val;
    logic [BW-1:0]      end_raddr;
    logic [BW-1:0]      ord_raddr;
    logic               ord_we;
    logic [BW-1:0]      ord_waddr;
    logic [BW-1:0]      ord_wdata;

    logic [BW-1:0]      x_bank;
    logic [16:0]        sum17;
    logic [END_W-1:0]   old_free;
    logic [END_W-1:0]   new_free;
    logic [END_W-1:0]   x_free_reg;
    logic [TOTAL_W-1:0] total_reg;

    // scan pipeline
    logic [CW-1:0]      scan_i_reg;
    logic               s1_reg, s2_reg;
    logic [BW-1:0]      pos1_reg, pos2_reg, b2_reg;
    logic [BW-1:0]      cnt_reg, q_reg;
    logic               q_found_reg;
    logic               scan_issue;
    logic [END_W-1:0]   scan_free;
    logic               goes_first;

    // shift pipeline
    logic [BW-1:0]      sh_j_reg, sh_rem_reg, sh_dst_reg;
    logic               sh_right_reg, sh1_reg;
    logic               sh_issue;
    logic               right;

    // query
    logic [8:0]         rk9, rk_c9;
    logic [BW-1:0]      rank_idx;
    logic [BW-1:0]      qb_reg;
    logic [7:0]         qb8;

    logic               div_busy;
    logic [PCT_W-1:0]   pct;
    logic               out_valid_reg;

    assign end_val = end_rv_reg ? end_rd_reg : ((end_ra_reg == '0) ? '0 : END_RST);
    assign ord_val = ord_rv_reg ? ord_rd_reg : ord_ra_reg;

    assign x_bank   = bank_reg[BW-1:0];
    assign sum17    = {1'b0, addr_reg} + {1'b0, len_reg};
    assign old_free = bank_free(x_bank == '0, end_val);
    assign new_free = bank_free(x_bank == '0, sum17[15:0]);

    assign rk9      = 9'(rank_reg);
    assign rk_c9    = (rk9 >= 9'(NUM_BANKS)) ? 9'(NUM_BANKS - 1) : rk9;
    assign rank_idx = rk_c9[BW-1:0];

    // a query keeps reading its bank's end while the result waits
    assign end_raddr = cmd.rec_rd ? x_bank : ((mode_reg && !cmd.q_end) ? qb_reg : ord_val);
    assign ord_raddr = cmd.q_ord ? rank_idx : (cmd.shift_run ? sh_j_reg : scan_i_reg[BW-1:0]);

    assign ord_we    = cmd.place || sh1_reg;
    assign ord_waddr = cmd.place ? cnt_reg : sh_dst_reg;
    assign ord_wdata = cmd.place ? x_bank : ord_val;

    assign scan_issue = cmd.scan_run && (scan_i_reg != CW'(NUM_BANKS));
    assign scan_free  = bank_free(b2_reg == '0, end_val);
    assign goes_first = (scan_free > x_free_reg) ||
                        ((scan_free == x_free_reg) && (b2_reg < x_bank));

    assign right    = (cnt_reg < q_reg);
    assign sh_issue = cmd.shift_run && (sh_rem_reg != '0);

    // memory ports
    always_ff @(posedge clk)
    begin
        end_rd_reg <= end_mem[end_raddr];
        end_ra_reg <= end_raddr;
        ord_rd_reg <= ord_mem[ord_raddr];
        ord_ra_reg <= ord_raddr;
        if (cmd.rec_upd)
            end_mem[x_bank] <= sum17[15:0];
        if (ord_we)
            ord_mem[ord_waddr] <= ord_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_vld_reg <= '0;
            ord_vld_reg <= '0;
            end_rv_reg  <= 1'b0;
            ord_rv_reg  <= 1'b0;
        end
        else
        begin
            end_rv_reg <= end_vld_reg[end_raddr];
            ord_rv_reg <= ord_vld_reg[ord_raddr];
            if (cmd.rec_upd)
                end_vld_reg[x_bank] <= 1'b1;
            if (ord_we)
                ord_vld_reg[ord_waddr] <= 1'b1;
        end
    end

    // capture and record update
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            bank_reg <= bank;
            addr_reg <= address;
            len_reg  <= length;
            rank_reg <= rank;
        end
        if (cmd.rec_upd)
            x_free_reg <= new_free;
        if (cmd.q_end)
            qb_reg <= ord_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_reg <= TOTAL_RST;
        else if (cmd.rec_upd)
            total_reg <= total_reg + TOTAL_W'(new_free) - TOTAL_W'(old_free);
    end

    // scan: count banks that rank ahead of the changed one, find its old slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_i_reg  <= '0;
            s1_reg      <= 1'b0;
            s2_reg      <= 1'b0;
            q_found_reg <= 1'b0;
        end
        else
        begin
            s1_reg <= scan_issue;
            s2_reg <= s1_reg;
            if (cmd.scan_start)
            begin
                scan_i_reg  <= '0;
                q_found_reg <= 1'b0;
            end
            else
            begin
                if (scan_issue)
                    scan_i_reg <= scan_i_reg + CW'(1);
                if (s2_reg && b2_reg == x_bank)
                    q_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos1_reg <= scan_i_reg[BW-1:0];
        pos2_reg <= pos1_reg;
        b2_reg   <= ord_val;
        if (cmd.scan_start)
            cnt_reg <= '0;
        else if (s2_reg)
        begin
            if (b2_reg == x_bank)
                q_reg <= pos2_reg;
            else if (goes_first)
                cnt_reg <= cnt_reg + BW'(1);
        end
    end

    // shift: move the entries between old and new slot by one place
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh1_reg    <= 1'b0;
            sh_rem_reg <= '0;
        end
        else
        begin
            sh1_reg <= sh_issue;
            if (cmd.shift_start)
                sh_rem_reg <= right ? (q_reg - cnt_reg) : (cnt_reg - q_reg);
            else if (sh_issue)
                sh_rem_reg <= sh_rem_reg - BW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift_start)
        begin
            sh_right_reg <= right;
            sh_j_reg     <= right ? (q_reg - BW'(1)) : (q_reg + BW'(1));
        end
        else if (sh_issue)
        begin
            sh_j_reg   <= sh_right_reg ? (sh_j_reg - BW'(1)) : (sh_j_reg + BW'(1));
            sh_dst_reg <= sh_right_reg ? (sh_j_reg + BW'(1)) : (sh_j_reg - BW'(1));
        end
    end

    rbfsr_div #(
        .NUM_BANKS (NUM_BANKS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .total (total_reg),
        .busy  (div_busy),
        .pct   (pct)
    );

    // result register
    assign qb8 = 8'(qb_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.res_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            if (mode_reg)
            begin
                error              <= 1'b0;
                ranked_bank        <= qb8[6:0];
                ranked_free        <= bank_free(qb_reg == '0, end_val);
                ranked_end         <= end_val;
                total_free         <= total_reg;
                percent_hundredths <= pct;
            end
            else
            begin
                error              <= stat.bank_bad;
                ranked_bank        <= '0;
                ranked_free        <= '0;
                ranked_end         <= '0;
                total_free         <= '0;
                percent_hundredths <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;

    assign stat.mode       = mode_reg;
    assign stat.bank_bad   = ({1'b0, bank_reg} >= 9'(NUM_BANKS));
    assign stat.upd        = (sum17 > {1'b0, end_val});
    assign stat.scan_done  = (scan_i_reg == CW'(NUM_BANKS)) && !s1_reg && !s2_reg;
    assign stat.shift_done = (sh_rem_reg == '0) && !sh1_reg;
    assign stat.div_busy   = div_busy;
    assign stat.out_free   = !out_valid_reg || out_ready;

    a_slot_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_start |-> q_found_reg)
        else $error("changed bank not found in rank order");

    a_shift_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (sh1_reg && sh_issue) |-> (sh_dst_reg != sh_j_reg))
        else $error("shift writes the slot it reads");

    a_shift_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_start |=> (CW'(sh_rem_reg) < CW'(NUM_BANKS)))
        else $error("shift distance out of range");

endmodule

FILE: rtl/rbfsr_ctrl.sv
// ----------------------------------------------------------------------------
// rbfsr_ctrl
// Sequencer: steps one item through record update, re-rank and percentage,
// or through the two reads of a query.
// ----------------------------------------------------------------------------
module rbfsr_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output rbfsr_pkg::rbfsr_cmd_t   cmd,
    input  rbfsr_pkg::rbfsr_stat_t  stat
);
    import rbfsr_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_REC_RD   = 11'b000_0000_0010,
        S_REC_CHK  = 11'b000_0000_0100,
        S_SCAN     = 11'b000_0000_1000,
        S_SHIFT    = 11'b000_0001_0000,
        S_PLACE    = 11'b000_0010_0000,
        S_DIV_GO   = 11'b000_0100_0000,
        S_DIV_WAIT = 11'b000_1000_0000,
        S_Q_ORD    = 11'b001_0000_0000,
        S_Q_END    = 11'b010_0000_0000,
        S_RESULT   = 11'b100_0000_0000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_REC_RD;
                end
            end
            S_REC_RD:
            begin
                cmd.rec_rd = 1'b1;
                if (stat.mode)
                    state_next = S_Q_ORD;
                else if (stat.bank_bad)
                    state_next = S_RESULT;
                else
                    state_next = S_REC_CHK;
            end
            S_REC_CHK:
            begin
                if (stat.upd)
                begin
                    cmd.rec_upd    = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                    state_next = S_RESULT;
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done)
                begin
                    cmd.shift_start = 1'b1;
                    state_next      = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift_run = 1'b1;
                if (stat.shift_done)
                    state_next = S_PLACE;
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (!stat.div_busy)
                    state_next = S_RESULT;
            end
            S_Q_ORD:
            begin
                cmd.q_ord  = 1'b1;
                state_next = S_Q_END;
            end
            S_Q_END:
            begin
                cmd.q_end  = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: rtl/rom_bank_free_space_ranker_top.sv
// ----------------------------------------------------------------------------
// rom_bank_free_space_ranker_top
// Tracks the highest used end address per ROM bank and answers rank queries
// in descending free-space order.
// ----------------------------------------------------------------------------
// Query: the sequencer reads the rank order, then that bank's end, and registers
// the result. A record that raises a bank end runs the record read and check,
// the rank-order scan, the one-port shift walk, placement and the percentage
// unit before its result registers; a record with no change or a bad bank skips
// to the result. One item at a time: the next is taken the cycle after the
// result registers, and a result still waiting holds the sequencer. Reset is
// asynchronous, active low; the tables come up in their reset state at once
// through per-entry valid bits, with no clearing pass.
module rom_bank_free_space_ranker_top #(
    parameter int NUM_BANKS = rbfsr_pkg::NUM_BANKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic [7:0]                      bank,
    input  logic [15:0]                     address,
    input  logic [15:0]                     length,
    input  logic [6:0]                      rank,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            error,
    output logic [6:0]                      ranked_bank,
    output logic [15:0]                     ranked_free,
    output logic [15:0]                     ranked_end,
    output logic [rbfsr_pkg::TOTAL_W-1:0]   total_free,
    output logic [rbfsr_pkg::PCT_W-1:0]     percent_hundredths
);
    import rbfsr_pkg::*;

    rbfsr_cmd_t  cmd;
    rbfsr_stat_t stat;

    rbfsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    rbfsr_dp #(
        .NUM_BANKS (NUM_BANKS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .mode               (mode),
        .bank               (bank),
        .address            (address),
        .length             (length),
        .rank               (rank),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .error              (error),
        .ranked_bank        (ranked_bank),
        .ranked_free        (ranked_free),
        .ranked_end         (ranked_end),
        .total_free         (total_free),
        .percent_hundredths (percent_hundredths),
        .cmd                (cmd),
        .stat               (stat)
    );

endmodule
